[rtl/core/utv_pkg.sv]
// Shared types and constants for the UTF-8 text validator.
`timescale 1ns / 1ps

package utv_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CFG_W           = 16;
	localparam int CFG_INDEX_W     = 2;
	localparam int CHAR_OUT_W      = 16;

	localparam logic [CFG_W-1:0] MAX_TEXT_BYTES_RST = 16'd1024;
	localparam logic [CFG_W-1:0] MAX_CHARS_RST      = 16'd256;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TEXT_BYTES = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CHARS      = 2'd1;

	// Constraint on the byte after a lead byte.
	typedef enum logic [2:0] {
		RULE_NONE   = 3'd0,
		RULE_MIN_A0 = 3'd1,
		RULE_MAX_9F = 3'd2,
		RULE_MIN_90 = 3'd3,
		RULE_MAX_8F = 3'd4
	} rule_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BYTES     = 2'd1,
		STAT_MALFORMED = 2'd2,
		STAT_CHARS     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] pending;
		rule_t      rule;
		logic       malformed;
	} scan_t;

	typedef struct packed {
		logic                  text_valid;
		logic [CHAR_OUT_W-1:0] char_count;
		status_t               status;
	} result_t;

endpackage

[rtl/core/utv_byte_check.sv]
// Per-byte UTF-8 decode: next scan state and character-complete flag.
`timescale 1ns / 1ps

module utv_byte_check (
	input  logic [7:0]    data_byte,
	input  utv_pkg::scan_t scan,
	output utv_pkg::scan_t scan_next,
	output logic          char_done
);

	logic rule_ok;

	always_comb begin
		case (scan.rule)
			utv_pkg::RULE_MIN_A0: rule_ok = (data_byte >= 8'ha0);
			utv_pkg::RULE_MAX_9F: rule_ok = (data_byte <  8'ha0);
			utv_pkg::RULE_MIN_90: rule_ok = (data_byte >= 8'h90);
			utv_pkg::RULE_MAX_8F: rule_ok = (data_byte <  8'h90);
			default:              rule_ok = 1'b1;
		endcase
	end

	always_comb begin
		scan_next = scan;
		char_done = 1'b0;
		if (scan.malformed) begin
			// fault latched: bytes only counted until end of text
		end else if (scan.pending != 2'd0) begin
			if (data_byte[7:6] != 2'b10 || !rule_ok) begin
				scan_next.malformed = 1'b1;
			end else begin
				scan_next.rule    = utv_pkg::RULE_NONE;
				scan_next.pending = scan.pending - 2'd1;
				char_done         = (scan.pending == 2'd1);
			end
		end else if (!data_byte[7]) begin
			// ASCII: controls below 0x20 rejected except tab and newline
			if (data_byte >= 8'd32 || data_byte == 8'h0a || data_byte == 8'h09) begin
				char_done = 1'b1;
			end else begin
				scan_next.malformed = 1'b1;
			end
		end else begin
			scan_next.rule = utv_pkg::RULE_NONE;
			if (data_byte >= 8'hc2 && data_byte <= 8'hdf) begin
				scan_next.pending = 2'd1;
			end else if (data_byte >= 8'he0 && data_byte <= 8'hef) begin
				scan_next.pending = 2'd2;
				if (data_byte == 8'he0) begin
					scan_next.rule = utv_pkg::RULE_MIN_A0;
				end else if (data_byte == 8'hed) begin
					scan_next.rule = utv_pkg::RULE_MAX_9F;
				end
			end else if (data_byte >= 8'hf0 && data_byte <= 8'hf4) begin
				scan_next.pending = 2'd3;
				if (data_byte == 8'hf0) begin
					scan_next.rule = utv_pkg::RULE_MIN_90;
				end else if (data_byte == 8'hf4) begin
					scan_next.rule = utv_pkg::RULE_MAX_8F;
				end
			end else begin
				scan_next.malformed = 1'b1;
			end
		end
	end

endmodule

[rtl/core/utf8_text_validator_unit.sv]
// Top level of the UTF-8 text validator with character count.
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// input     in   in_valid / in_stall  data_byte[7:0] (zero ends the text)
// output    out  out_valid/ out_stall text_valid, char_count[15:0], status[1:0]
// config    in   cfg_we               cfg_index[1:0], cfg_data[15:0]
//
// One byte per cycle while in_stall is low. A non-zero byte updates the scan
// state and counters in the cycle it is accepted; a zero byte writes the result
// to the output register at the same edge, or to the skid register on a stall.
// The output register is backed by a one-entry skid register; in_stall rises
// only while the skid register is full.
// Reset (arst_n low) clears scan state, counters and the valid flags of both
// output stages and loads the limits with 1024 bytes and 256 characters.

module utf8_text_validator_unit #(
	parameter int COUNT_WIDTH = utv_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          data_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                text_valid,
	output logic [utv_pkg::CHAR_OUT_W-1:0]      char_count,
	output logic [1:0]                          status,
	input  logic                                cfg_we,
	input  logic [utv_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [utv_pkg::CFG_W-1:0]           cfg_data
);

	// compare width covers both the counters and the 16-bit limits
	localparam int CMP_W = (COUNT_WIDTH > utv_pkg::CFG_W) ? COUNT_WIDTH : utv_pkg::CFG_W;

	logic [utv_pkg::CFG_W-1:0] max_bytes_q;
	logic [utv_pkg::CFG_W-1:0] max_chars_q;

	utv_pkg::scan_t            scan_q;
	utv_pkg::scan_t            scan_next;
	logic                      char_done;
	logic [COUNT_WIDTH-1:0]    byte_total_q;
	logic [COUNT_WIDTH-1:0]    char_total_q;

	utv_pkg::result_t          result;
	utv_pkg::status_t          stat;
	utv_pkg::result_t          out_q;
	utv_pkg::result_t          skid_q;
	logic                      out_valid_q;
	logic                      skid_valid_q;

	logic                      in_xact;
	logic                      end_of_text;
	logic                      out_ready;

	assign in_stall    = skid_valid_q;
	assign in_xact     = in_valid && !skid_valid_q;
	assign end_of_text = in_xact && (data_byte == 8'd0);
	assign out_ready   = !out_valid_q || !out_stall;

	// Limit registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= utv_pkg::MAX_TEXT_BYTES_RST;
			max_chars_q <= utv_pkg::MAX_CHARS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				utv_pkg::CFG_MAX_TEXT_BYTES: max_bytes_q <= cfg_data;
				utv_pkg::CFG_MAX_CHARS:      max_chars_q <= cfg_data;
				default: ;
			endcase
		end
	end

	utv_byte_check u_byte_check (
		.data_byte (data_byte),
		.scan      (scan_q),
		.scan_next (scan_next),
		.char_done (char_done)
	);

	// Scan state and saturating counters; all cleared on end of text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '{pending: 2'd0, rule: utv_pkg::RULE_NONE, malformed: 1'b0};
			byte_total_q <= '0;
			char_total_q <= '0;
		end else if (end_of_text) begin
			scan_q       <= '{pending: 2'd0, rule: utv_pkg::RULE_NONE, malformed: 1'b0};
			byte_total_q <= '0;
			char_total_q <= '0;
		end else if (in_xact) begin
			scan_q <= scan_next;
			if (byte_total_q != '1) begin
				byte_total_q <= byte_total_q + 1'b1;
			end
			if (char_done && char_total_q != '1) begin
				char_total_q <= char_total_q + 1'b1;
			end
		end
	end

	// Verdict: byte limit first, then encoding, then character limit.
	always_comb begin
		if (CMP_W'(byte_total_q) >= CMP_W'(max_bytes_q)) begin
			stat = utv_pkg::STAT_BYTES;
		end else if (scan_q.malformed || scan_q.pending != 2'd0) begin
			stat = utv_pkg::STAT_MALFORMED;
		end else if (CMP_W'(char_total_q) > CMP_W'(max_chars_q)) begin
			stat = utv_pkg::STAT_CHARS;
		end else begin
			stat = utv_pkg::STAT_OK;
		end

		result.text_valid = (stat == utv_pkg::STAT_OK);
		result.status     = stat;
		if (stat == utv_pkg::STAT_OK || stat == utv_pkg::STAT_CHARS) begin
			if (CMP_W'(char_total_q) > CMP_W'({utv_pkg::CHAR_OUT_W{1'b1}})) begin
				result.char_count = '1;
			end else begin
				result.char_count = utv_pkg::CHAR_OUT_W'(char_total_q);
			end
		end else begin
			result.char_count = '0;
		end
	end

	// Output register plus skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= end_of_text;
			end
		end else if (end_of_text) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (end_of_text) begin
				out_q <= result;
			end
		end else if (end_of_text) begin
			skid_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign text_valid = out_q.text_valid;
	assign char_count = out_q.char_count;
	assign status     = out_q.status;

endmodule
